### src/lbp_pkg.sv
// Package for the 3x3 local binary pattern stream block.
// Holds the request types, register indexes and shared constants.
// Used by every module under src.
`default_nettype none

package lbp_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int ROW_BITS      = 10;
    localparam int CFG_BITS      = 11;
    localparam int CODE_BITS     = 8;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_start;
    } pixel_req_t;

    typedef struct packed {
        logic [CODE_BITS-1:0] lbp_code;
        logic                 row_end;
        logic                 frame_end;
    } code_req_t;

    typedef struct packed {
        logic has_code;
        logic last_col;
        logic last_row;
    } scan_info_t;

endpackage

`default_nettype wire

### src/lbp_3x3_code_stream_top.sv
// Top level of the 3x3 local binary pattern code stream.
// Instantiates lbp_scan, lbp_line_mem and lbp_window; depends on lbp_pkg.
//
// Usage:
// Pixels enter in raster order on the pixel channel (valid/ready, payload
// pixel_req). A request with frame_start set is pixel (0,0) of a new frame.
// Codes leave on the code channel (valid/ready, payload code_req), one for
// every pixel at row 2 or later and column 2 or later, so a frame gives
// (height-2) x (width-2) codes. row_end marks the last code of an output
// row, frame_end the last code of the frame.
// Frame size is set through cfg_we, cfg_index and cfg_data while the block
// is idle: index 0 is the width, index 1 the height.
// Throughput is one pixel per cycle while the code channel does not stall. A
// pixel reads the line store memory in the cycle it is accepted; the read
// data waits with the pixel in the memory stage, and its code is then
// registered in the output register. The line store's read-modify-write
// loop sets this rate; a write to the entry being read is forwarded.
// Reset clears the counters and window and sets the size registers to 640 x 480;
// line store contents stay undefined and are written before any code uses them.
// When the receiver stalls, one code waits in the output register and the
// next pixel that has a code waits in the memory stage; border pixels pass
// on. pixel_ready then drops until the waiting code is taken.
`default_nettype none

module lbp_3x3_code_stream_top #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [lbp_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic                         pixel_valid,
    output logic                              pixel_ready,
    input  wire lbp_pkg::pixel_req_t          pixel_req,
    output logic                              code_valid,
    input  wire logic                         code_ready,
    output lbp_pkg::code_req_t                code_req
);
    import lbp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = 2 * PIXEL_BITS;

    logic                  accept;
    logic                  s1_advance;
    logic [CW-1:0]         col;
    scan_info_t            info;

    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_px_reg;
    logic [CW-1:0]         s1_col_reg;
    scan_info_t            s1_info_reg;
    logic                  s1_fwd_reg;
    logic [DW-1:0]         s1_fwd_data_reg;

    logic [DW-1:0]         rd_data;
    logic [DW-1:0]         line_word;
    logic [DW-1:0]         wr_data;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] mid;
    logic [CODE_BITS-1:0]  code;

    logic                  code_valid_reg;
    code_req_t             code_req_reg;

    assign s1_advance  = s1_valid_reg && (!s1_info_reg.has_code || !code_valid_reg || code_ready);
    assign pixel_ready = !s1_valid_reg || s1_advance;
    assign accept      = pixel_valid && pixel_ready;

    lbp_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (accept),
        .frame_start (pixel_req.frame_start),
        .col         (col),
        .info        (info)
    );

    lbp_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (DW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (s1_advance),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    assign line_word = s1_fwd_reg ? s1_fwd_data_reg : rd_data;
    assign up        = line_word[DW-1:PIXEL_BITS];
    assign mid       = line_word[PIXEL_BITS-1:0];
    assign wr_data   = {mid, s1_px_reg};

    lbp_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (s1_advance),
        .up    (up),
        .mid   (mid),
        .px    (s1_px_reg),
        .code  (code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pixel_ready)
            s1_valid_reg <= pixel_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixel_req.pixel;
            s1_col_reg      <= col;
            s1_info_reg     <= info;
            s1_fwd_reg      <= s1_advance && (s1_col_reg == col);
            s1_fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            code_valid_reg <= 1'b0;
        else if (s1_advance && s1_info_reg.has_code)
            code_valid_reg <= 1'b1;
        else if (code_ready)
            code_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_info_reg.has_code)
        begin
            code_req_reg.lbp_code  <= code;
            code_req_reg.row_end   <= s1_info_reg.last_col;
            code_req_reg.frame_end <= s1_info_reg.last_col && s1_info_reg.last_row;
        end
    end

    assign code_valid = code_valid_reg;
    assign code_req   = code_req_reg;

    a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid |-> (!code_req.frame_end || code_req.row_end))
        else $error("frame_end without row_end");

    a_ready_when_sink_ready: assert property (@(posedge clk) disable iff (!rst_n)
        code_ready |-> pixel_ready)
        else $error("pixel channel stalled while code sink is ready");

    a_code_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(code_valid) |-> $past(s1_valid_reg))
        else $error("code shown without a pixel in the memory stage");

endmodule

`default_nettype wire

### src/lbp_scan.sv
// Raster position tracking and frame size registers.
// Clamps the configured size and flags the border, the last column and the last row.
// Depends on lbp_pkg.
`default_nettype none

module lbp_scan #(
    parameter int MAX_WIDTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [lbp_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic                         step,
    input  wire logic                         frame_start,
    output logic      [CW-1:0]                col,
    output lbp_pkg::scan_info_t               info
);
    import lbp_pkg::*;

    localparam int CMPW = (CW + 1 > CFG_BITS) ? CW + 1 : CFG_BITS;

    logic [CFG_BITS-1:0] frame_width_reg;
    logic [CFG_BITS-1:0] frame_height_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [ROW_BITS-1:0] row_reg, row_next;
    logic [ROW_BITS-1:0] row;
    logic [CMPW-1:0]     fw_ext;
    logic [CW-1:0]       wlast;
    logic [ROW_BITS-1:0] hlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        fw_ext = CMPW'(frame_width_reg);
        if (fw_ext < CMPW'(3))
            wlast = CW'(2);
        else if (fw_ext > CMPW'(MAX_WIDTH))
            wlast = CW'(MAX_WIDTH - 1);
        else
            wlast = CW'(fw_ext - CMPW'(1));

        if (frame_height_reg < CFG_BITS'(3))
            hlast = ROW_BITS'(2);
        else if (frame_height_reg > CFG_BITS'(HEIGHT_LIMIT))
            hlast = ROW_BITS'(HEIGHT_LIMIT - 1);
        else
            hlast = ROW_BITS'(frame_height_reg - CFG_BITS'(1));
    end

    always_comb
    begin
        col = frame_start ? '0 : col_reg;
        row = frame_start ? '0 : row_reg;
        info.last_col = (col >= wlast);
        info.last_row = (row >= hlast);
        info.has_code = (row >= ROW_BITS'(2)) && (col >= CW'(2));
        if (info.last_col)
        begin
            col_next = '0;
            row_next = info.last_row ? '0 : row + ROW_BITS'(1);
        end
        else
        begin
            col_next = col + CW'(1);
            row_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### src/lbp_line_mem.sv
// Line store memory holding the upper and middle rows side by side.
// One write port and one read port, read data registered.
// Depends on lbp_pkg.
`default_nettype none

module lbp_line_mem #(
    parameter int DEPTH = lbp_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 2 * lbp_pkg::PIXEL_BITS
) (
    input  wire logic          clk,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);
    import lbp_pkg::*;

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/lbp_window.sv
// 3x3 window registers and the neighbor comparison.
// The right column comes straight from the line stores and the new pixel.
// Depends on lbp_pkg.
`default_nettype none

module lbp_window (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           shift,
    input  wire logic [lbp_pkg::PIXEL_BITS-1:0] up,
    input  wire logic [lbp_pkg::PIXEL_BITS-1:0] mid,
    input  wire logic [lbp_pkg::PIXEL_BITS-1:0] px,
    output logic      [lbp_pkg::CODE_BITS-1:0]  code
);
    import lbp_pkg::*;

    logic [PIXEL_BITS-1:0] left_reg [3];
    logic [PIXEL_BITS-1:0] centre_reg [3];
    logic [PIXEL_BITS-1:0] ctr;

    always_comb
    begin
        ctr     = centre_reg[1];
        code[7] = left_reg[0] > ctr;
        code[6] = centre_reg[0] > ctr;
        code[5] = up > ctr;
        code[4] = mid > ctr;
        code[3] = px > ctr;
        code[2] = centre_reg[2] > ctr;
        code[1] = left_reg[2] > ctr;
        code[0] = left_reg[1] > ctr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                left_reg[i]   <= '0;
                centre_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            left_reg      <= centre_reg;
            centre_reg[0] <= up;
            centre_reg[1] <= mid;
            centre_reg[2] <= px;
        end
    end

endmodule

`default_nettype wire

### verif/lbp_3x3_code_stream_top_tb.sv
// Self-checking testbench for lbp_3x3_code_stream_top, using lbp_pkg for the request types.
// Pixel requests are driven with random idling, and an internal line-store predictor
// checks every code request.
`timescale 1ns / 1ps

module lbp_3x3_code_stream_top_tb;
    import lbp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned QUIET_LIMIT  = 1000;
    localparam int unsigned BIG_SIDE     = 1024;

    typedef struct {
        bit        typed;
        bit        has_code;
        code_req_t res;
    } known_result_t;

    typedef struct {
        pixel_req_t    item;
        known_result_t note;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = REG_FRAME_WIDTH;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic                pixel_valid = 1'b0;
    logic                pixel_ready;
    pixel_req_t          pixel_req = '0;
    logic                code_valid;
    logic                code_ready = 1'b0;
    code_req_t           code_req;

    logic [PIXEL_BITS-1:0] store_upper [MAX_WIDTH_DEF];
    logic [PIXEL_BITS-1:0] store_middle [MAX_WIDTH_DEF];
    logic [PIXEL_BITS-1:0] window_px [6] = '{default: '0};
    int unsigned           scan_col = 0;
    int unsigned           scan_row = 0;
    int unsigned           narrow_width = 640;
    logic [CFG_BITS-1:0]   width_reg = FRAME_WIDTH_RESET;
    logic [CFG_BITS-1:0]   height_reg = FRAME_HEIGHT_RESET;

    known_result_t known_results[$];
    code_req_t     pending_codes[$];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles = 0;
    int unsigned   sender_idle_pct = 7;
    int unsigned   receiver_idle_pct = 49;

    lbp_3x3_code_stream_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_req   (pixel_req),
        .code_valid  (code_valid),
        .code_ready  (code_ready),
        .code_req    (code_req)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(input logic [CFG_BITS-1:0] v,
                                               input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void predict_code(input pixel_req_t item, output bit has_code,
                                         output code_req_t res);
        int unsigned           w;
        int unsigned           h;
        int unsigned           c;
        int unsigned           r;
        logic [PIXEL_BITS-1:0] up;
        logic [PIXEL_BITS-1:0] mid;
        logic [PIXEL_BITS-1:0] ctr;
        logic [PIXEL_BITS-1:0] nb [8];
        bit                    last_col;
        bit                    last_row;
        w = clamp_size(width_reg, MAX_WIDTH_DEF);
        h = clamp_size(height_reg, HEIGHT_LIMIT);
        if (item.frame_start)
        begin
            scan_col = 0;
            scan_row = 0;
        end
        c = scan_col;
        r = scan_row;
        if (c == 0 && r == 0)
            narrow_width = w;
        else if (w < narrow_width)
            narrow_width = w;
        up = '0;
        mid = '0;
        if (c < MAX_WIDTH_DEF)
        begin
            up = store_upper[c];
            mid = store_middle[c];
            store_upper[c] = mid;
            store_middle[c] = item.pixel;
        end
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        has_code = (r >= 2 && c >= 2);
        res = '0;
        if (has_code)
        begin
            ctr = window_px[4];
            nb = '{window_px[0], window_px[3], up, mid, item.pixel,
                   window_px[5], window_px[2], window_px[1]};
            for (int i = 0; i < 8; i++)
                res.lbp_code[7 - i] = (nb[i] > ctr);
            res.row_end = last_col;
            res.frame_end = last_col && last_row;
        end
        window_px[0] = window_px[3];
        window_px[1] = window_px[4];
        window_px[2] = window_px[5];
        window_px[3] = up;
        window_px[4] = mid;
        window_px[5] = item.pixel;
        if (last_col)
        begin
            scan_col = 0;
            scan_row = last_row ? 0 : r + 1;
        end
        else
        begin
            scan_col = c + 1;
        end
    endfunction

    function automatic stim_row_t make_row(input logic [PIXEL_BITS-1:0] px, input bit fs,
                                           input bit typed, input bit has,
                                           input logic [CODE_BITS-1:0] code,
                                           input bit re, input bit fe);
        stim_row_t row;
        row.item.pixel = px;
        row.item.frame_start = fs;
        row.note.typed = typed;
        row.note.has_code = has;
        row.note.res.lbp_code = code;
        row.note.res.row_end = re;
        row.note.res.frame_end = fe;
        return row;
    endfunction

    task automatic send_pixel(input pixel_req_t item, input known_result_t note);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        known_results.push_back(note);
        pixel_valid <= 1'b1;
        pixel_req <= item;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        pixel_valid <= 1'b0;
        while (pending_codes.size() != 0 || known_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_frame_size(input logic [CFG_BITS-1:0] width_val,
                                    input logic [CFG_BITS-1:0] height_val);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= width_val;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= height_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = width_val;
        height_reg = height_val;
    endtask

    task automatic send_frames(input int unsigned n_items, input int unsigned style,
                               input bit fs_first, input int unsigned noise_pct);
        pixel_req_t    item;
        known_result_t note;
        note = '{typed: 1'b0, has_code: 1'b0, res: '0};
        for (int unsigned i = 0; i < n_items; i++)
        begin
            case (style)
                0: item.pixel = $urandom_range(0, 255);
                1: item.pixel = $urandom_range(0, 3);
                default: item.pixel = $urandom_range(0, 1) ? '1 : '0;
            endcase
            item.frame_start = (i == 0 && fs_first) || ($urandom_range(0, 99) < noise_pct);
            send_pixel(item, note);
        end
    endtask

    always @(posedge clk)
        code_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        known_result_t note;
        code_req_t     want;
        bit            has;
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                note = known_results.pop_front();
                predict_code(pixel_req, has, want);
                if (note.typed)
                begin
                    has = note.has_code;
                    want = note.res;
                end
                if (has)
                    pending_codes.push_back(want);
            end
            if (code_valid && code_ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    $error("code request with none pending: lbp_code %0h", code_req.lbp_code);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (code_req.lbp_code !== want.lbp_code)
                    begin
                        $error("lbp_code: expected %0h, actual %0h",
                               want.lbp_code, code_req.lbp_code);
                        mismatch_count++;
                    end
                    if (code_req.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0b, actual %0b",
                               want.row_end, code_req.row_end);
                        mismatch_count++;
                    end
                    if (code_req.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, code_req.frame_end);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && pixel_ready) || (code_valid && code_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("lbp_3x3_code_stream_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        stim_row_t             rows[$];
        logic [PIXEL_BITS-1:0] broken_px [4] = '{8'd17, 8'd200, 8'h00, 8'hFF};
        logic [CFG_BITS-1:0]   w_val;
        logic [CFG_BITS-1:0]   h_val;
        int unsigned           eff_w;
        int unsigned           eff_h;
        int unsigned           n_items;
        int unsigned           random_count;
        bit                    fs_first;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both sizes below the minimum, so the block works on 3x3 frames.
        write_frame_size('0, 11'd2);
        for (int k = 0; k < 4; k++)
            rows.push_back(make_row(broken_px[k], k == 0, 1'b0, 1'b0, '0, 1'b0, 1'b0));
        // A new frame starts in the middle of the abandoned one.
        for (int k = 0; k < 9; k++)
            rows.push_back(make_row((k == 4) ? 8'h00 : 8'hFF, k == 0, 1'b1, k == 8,
                                    8'hFF, 1'b1, 1'b1));
        // The next frame follows without a frame start; only the top-left neighbor is greater.
        for (int k = 0; k < 9; k++)
            rows.push_back(make_row((k == 0) ? 8'hFF : 8'h00, 1'b0, 1'b1, k == 8,
                                    8'h80, 1'b1, 1'b1));
        foreach (rows[i])
            send_pixel(rows[i].item, rows[i].note);

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (random_count < RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 7;
                receiver_idle_pct = 49;
            end
            else if (random_count < 2 * RANDOM_ITEMS / 3)
            begin
                sender_idle_pct = 49;
                receiver_idle_pct = 7;
            end
            else
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            w_val = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            case ($urandom_range(0, 14))
                0: h_val = $urandom_range(0, 2);
                1: h_val = $urandom_range(BIG_SIDE + 1, 2047);
                default: h_val = $urandom_range(3, 8);
            endcase
            wait_idle();
            write_frame_size(w_val, h_val);
            eff_w = clamp_size(w_val, MAX_WIDTH_DEF);
            eff_h = clamp_size(h_val, HEIGHT_LIMIT);
            // A wider row inside a running frame would read line store entries never written.
            fs_first = ((scan_col != 0 || scan_row != 0) && eff_w > narrow_width)
                       || ($urandom_range(0, 1) == 0);
            if (eff_h > 100)
                n_items = $urandom_range(eff_w * 3, eff_w * 10);
            else
                n_items = $urandom_range(eff_w * 2, eff_w * eff_h * 2);
            send_frames(n_items, $urandom_range(0, 2), fs_first, 1);
            random_count += n_items;
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_codes.size() == 0)
            $display("lbp_3x3_code_stream_top: match");
        else
            $display("lbp_3x3_code_stream_top: mismatch");
        $finish;
    end

endmodule
